/* rtl/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// types and constants shared by the point-in-triangle test pipeline
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int COORD_BITS     = 12;
	localparam int DIFF_BITS      = COORD_BITS + 1;
	localparam int PROD_BITS      = 2 * DIFF_BITS;
	localparam int CROSS_BITS     = PROD_BITS + 1;
	localparam int SUM_BITS       = CROSS_BITS + 1;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_A_X = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_A_Y = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_B_X = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_B_Y = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_C_X = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_C_Y = 3'd5;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic inside_res;
		logic degenerate;
	} result_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] a_x;
		logic [COORD_BITS-1:0] a_y;
		logic [COORD_BITS-1:0] b_x;
		logic [COORD_BITS-1:0] b_y;
		logic [COORD_BITS-1:0] c_x;
		logic [COORD_BITS-1:0] c_y;
	} vertex_t;

	// edge and point vectors relative to vertex a
	typedef struct packed {
		logic signed [DIFF_BITS-1:0] u_x;
		logic signed [DIFF_BITS-1:0] u_y;
		logic signed [DIFF_BITS-1:0] v_x;
		logic signed [DIFF_BITS-1:0] v_y;
		logic signed [DIFF_BITS-1:0] p_x;
		logic signed [DIFF_BITS-1:0] p_y;
	} diff_t;

	typedef struct packed {
		logic signed [PROD_BITS-1:0] uv_a;
		logic signed [PROD_BITS-1:0] uv_b;
		logic signed [PROD_BITS-1:0] pv_a;
		logic signed [PROD_BITS-1:0] pv_b;
		logic signed [PROD_BITS-1:0] up_a;
		logic signed [PROD_BITS-1:0] up_b;
	} prod_t;

	// pipeline advance and valid flags between stages
	typedef struct packed {
		logic en;
		logic valid;
	} stage_ctrl_t;

endpackage

/* rtl/ptt_diff.sv */
// ----------------------------------------------------------------------------
// ptt_diff
// first stage: edge and point vectors relative to vertex a
// ----------------------------------------------------------------------------
module ptt_diff import ptt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  stage_ctrl_t ctrl,
	input  pixel_t      pixel,
	input  vertex_t     vertex,
	output logic        valid_s1,
	output diff_t       diff_s1
);

	function automatic logic signed [DIFF_BITS-1:0] sub_coord(
		input logic [COORD_BITS-1:0] x,
		input logic [COORD_BITS-1:0] y
	);
		sub_coord = $signed({1'b0, x}) - $signed({1'b0, y});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctrl.en) begin
			valid_s1 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			diff_s1.u_x <= sub_coord(vertex.c_x, vertex.a_x);
			diff_s1.u_y <= sub_coord(vertex.c_y, vertex.a_y);
			diff_s1.v_x <= sub_coord(vertex.b_x, vertex.a_x);
			diff_s1.v_y <= sub_coord(vertex.b_y, vertex.a_y);
			diff_s1.p_x <= sub_coord(pixel.pixel_x, vertex.a_x);
			diff_s1.p_y <= sub_coord(pixel.pixel_y, vertex.a_y);
		end
	end

endmodule

/* rtl/ptt_prod.sv */
// ----------------------------------------------------------------------------
// ptt_prod
// second stage: the six products of the three cross products
// ----------------------------------------------------------------------------
module ptt_prod import ptt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  stage_ctrl_t ctrl,
	input  diff_t       diff_s1,
	output logic        valid_s2,
	output prod_t       prod_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ctrl.en) begin
			valid_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_s2.uv_a <= PROD_BITS'(diff_s1.u_x) * PROD_BITS'(diff_s1.v_y);
			prod_s2.uv_b <= PROD_BITS'(diff_s1.u_y) * PROD_BITS'(diff_s1.v_x);
			prod_s2.pv_a <= PROD_BITS'(diff_s1.p_x) * PROD_BITS'(diff_s1.v_y);
			prod_s2.pv_b <= PROD_BITS'(diff_s1.p_y) * PROD_BITS'(diff_s1.v_x);
			prod_s2.up_a <= PROD_BITS'(diff_s1.u_x) * PROD_BITS'(diff_s1.p_y);
			prod_s2.up_b <= PROD_BITS'(diff_s1.u_y) * PROD_BITS'(diff_s1.p_x);
		end
	end

endmodule

/* rtl/ptt_classify.sv */
// ----------------------------------------------------------------------------
// ptt_classify
// third and fourth stages: cross products, then the inside decision
// ----------------------------------------------------------------------------
module ptt_classify import ptt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  stage_ctrl_t ctrl,
	input  prod_t       prod_s2,
	output logic        valid_s4,
	output result_t     result_s4
);

	logic                         valid_s3;
	logic signed [CROSS_BITS-1:0] d_s3;
	logic signed [CROSS_BITS-1:0] e1_s3;
	logic signed [CROSS_BITS-1:0] e2_s3;
	logic signed [SUM_BITS-1:0]   sum;
	logic signed [SUM_BITS-1:0]   d_ext;
	logic                         d_neg;
	logic                         hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (ctrl.en) begin
			valid_s3 <= ctrl.valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			d_s3  <= CROSS_BITS'(prod_s2.uv_a) - CROSS_BITS'(prod_s2.uv_b);
			e1_s3 <= CROSS_BITS'(prod_s2.pv_a) - CROSS_BITS'(prod_s2.pv_b);
			e2_s3 <= CROSS_BITS'(prod_s2.up_a) - CROSS_BITS'(prod_s2.up_b);
		end
	end

	// negative area flips the sense of every comparison
	always_comb begin
		sum   = SUM_BITS'(e1_s3) + SUM_BITS'(e2_s3);
		d_ext = SUM_BITS'(d_s3);
		d_neg = d_s3[CROSS_BITS-1];
		if (d_neg) begin
			hit = (e1_s3 <= 0) && (e2_s3 <= 0) && (sum >= d_ext);
		end else begin
			hit = (e1_s3 >= 0) && (e2_s3 >= 0) && (sum <= d_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			result_s4.degenerate <= (d_s3 == '0);
			result_s4.inside_res <= (d_s3 != '0) && hit;
		end
	end

endmodule

/* rtl/point_in_triangle_test.sv */
// ----------------------------------------------------------------------------
// point_in_triangle_test
// barycentric point-in-triangle test against a triangle held in registers
// ----------------------------------------------------------------------------
// One pixel is accepted every clock while the pipeline advances; its result
// passes the vector, product, cross-product and decision register stages. The
// pipeline only holds when a result waits at the output and is not taken.
// Edges count as inside; a zero-area triangle (also the state after reset)
// reports degenerate and never inside. Vertex registers are written on the
// cfg channel, which is always ready; indices beyond vertex c y are ignored.
// Write them only while no pixel is in flight.
module point_in_triangle_test import ptt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]     cfg_data,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	input  pixel_t                    pixel,
	output logic                      result_valid,
	input  logic                      result_ready,
	output result_t                   result
);

	vertex_t     vertex_q;
	stage_ctrl_t ctrl_in;
	stage_ctrl_t ctrl_s1;
	stage_ctrl_t ctrl_s2;
	logic        valid_s1;
	logic        valid_s2;
	diff_t       diff_s1;
	prod_t       prod_s2;
	logic        adv;

	assign cfg_ready   = 1'b1;
	assign adv         = !result_valid || result_ready;
	assign pixel_ready = adv;

	assign ctrl_in = '{en: adv, valid: pixel_valid};
	assign ctrl_s1 = '{en: adv, valid: valid_s1};
	assign ctrl_s2 = '{en: adv, valid: valid_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_A_X: vertex_q.a_x <= cfg_data;
				REG_A_Y: vertex_q.a_y <= cfg_data;
				REG_B_X: vertex_q.b_x <= cfg_data;
				REG_B_Y: vertex_q.b_y <= cfg_data;
				REG_C_X: vertex_q.c_x <= cfg_data;
				REG_C_Y: vertex_q.c_y <= cfg_data;
				default: ;
			endcase
		end
	end

	ptt_diff u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_in),
		.pixel    (pixel),
		.vertex   (vertex_q),
		.valid_s1 (valid_s1),
		.diff_s1  (diff_s1)
	);

	ptt_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_s1),
		.diff_s1  (diff_s1),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2)
	);

	ptt_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_s2),
		.prod_s2   (prod_s2),
		.valid_s4  (result_valid),
		.result_s4 (result)
	);

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.inside_res && result.degenerate))
		else $error("inside and degenerate both set");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> valid_s1)
		else $error("accepted pixel missing from first stage");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |=> result_valid)
		else $error("result lost during stall");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s1) && $stable(valid_s2))
		else $error("pipeline moved during stall");

endmodule
